// ===== sv/hkms_pkg.sv =====
// Shared types, codes and constants for the haptic knob mode and setpoint block.
package hkms_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // pi in Q16.48
   localparam logic [63:0] PI_Q48 = 64'h0003_243F_6A88_85A3;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_MODE = 1'b1;

   localparam logic [2:0] KNOB_DISABLE = 3'd0;
   localparam logic [2:0] KNOB_INERTIA = 3'd1;
   localparam logic [2:0] KNOB_ENCODER = 3'd2;
   localparam logic [2:0] KNOB_SPRING  = 3'd3;
   localparam logic [2:0] KNOB_DAMPED  = 3'd4;
   localparam logic [2:0] KNOB_SPIN    = 3'd5;

   localparam logic [1:0] DRV_TORQUE   = 2'd0;
   localparam logic [1:0] DRV_VELOCITY = 2'd1;
   localparam logic [1:0] DRV_ANGLE    = 2'd2;

   localparam logic [1:0] CSR_ZERO_OFFSET = 2'd0;
   localparam logic [1:0] CSR_LIMIT_LOW   = 2'd1;
   localparam logic [1:0] CSR_LIMIT_HIGH  = 2'd2;
   localparam logic [1:0] CSR_DETENTS     = 2'd3;

   typedef struct packed {
      logic signed [31:0] zero_offset;
      logic signed [31:0] limit_low;
      logic signed [31:0] limit_high;
      logic [7:0]         detents_per_turn;
   } cfg_type;

   // Clamp a 33-bit signed value into 32 bits
   function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/haptic_knob_mode_setpoint_top.sv =====
// Haptic knob mode and setpoint block: one result per tick or mode-change
// transfer. A mode change or a tick outside encoder mode passes from acceptance
// through the position and execute states. An encoder tick also runs the divide
// and step states, waiting on the bit-serial divider that works out the detent
// step 2*pi/N and the half-step from detents_per_turn, one quotient bit per cycle
// over FRAC_BITS + 4 bits (20 at Q16.16). The result sits in an output
// register, so the next request is taken while the previous result waits; the
// block only holds off a finished item if that register is still full.
// Configuration writes are always ready and must be made while the block is idle.
module haptic_knob_mode_setpoint_top #(
   parameter int FRAC_BITS = hkms_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [2:0]         req_new_mode,
   input  logic signed [31:0] req_shaft_angle,
   input  logic signed [31:0] req_shaft_speed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_drive_mode,
   output logic signed [31:0] rsp_setpoint,
   output logic signed [31:0] rsp_detent_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import hkms_pkg::*;

   localparam int DIV_W = FRAC_BITS + 4;
   localparam logic [63:0] PI_SHIFTED = PI_Q48 >> (46 - FRAC_BITS);
   localparam logic [DIV_W-1:0] DIVIDEND = PI_SHIFTED[DIV_W-1:0];

   localparam longint ONE_L  = longint'(1) << FRAC_BITS;
   localparam longint T42_L  = (42 * ONE_L + 5) / 10;
   localparam longint T03_L  = (3 * ONE_L + 5) / 10;
   localparam longint SPIN_L = 20 * ONE_L;

   localparam logic signed [31:0] TGT_42   = 32'(T42_L);
   localparam logic signed [31:0] TGT_SPIN = 32'(SPIN_L);
   localparam logic signed [32:0] ONE_X    = 33'(ONE_L);
   localparam logic signed [32:0] NONE_X   = 33'(-ONE_L);
   localparam logic signed [32:0] TH_X     = 33'(T03_L);
   localparam logic signed [32:0] NTH_X    = 33'(-T03_L);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_POS  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_STEP = 5'b01000,
      ST_EXEC = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   cfg_type cfg;

   // captured request
   logic               kind_ff;
   logic [2:0]         new_mode_ff;
   logic signed [31:0] angle_ff, speed_ff;

   // working values
   logic signed [31:0] pos_ff, pos_in;
   logic signed [32:0] d_ff, d_in;
   logic signed [32:0] half_ff, half_in, step_ff, step_in;

   // knob state
   logic [2:0]         knob_mode_ff, knob_mode_in;
   logic signed [31:0] prev_angle_ff, prev_angle_in;
   logic signed [31:0] prev_speed_ff, prev_speed_in;
   logic signed [31:0] target_ff, target_in;
   logic [1:0]         drive_ff, drive_in;
   logic [31:0]        detent_ff, detent_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_drive_ff;
   logic signed [31:0] rsp_setpoint_ff, rsp_detent_ff;

   logic               div_start, div_done;
   logic [7:0]         div_divisor;
   logic [DIV_W-1:0]   div_quo;

   logic               accept, out_free, commit;
   logic signed [32:0] ang_diff, spd_diff, tgt_up, tgt_dn;
   logic [DIV_W:0]     r2_inc, r1_inc;

   hkms_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hkms_div #(.W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .dividend (DIVIDEND),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_EXEC) && out_free;

   assign div_divisor = (cfg.detents_per_turn == 8'd0) ? 8'd1 : cfg.detents_per_turn;
   assign div_start   = (state_ff == ST_POS) && (kind_ff == KIND_TICK)
                        && (knob_mode_ff == KNOB_ENCODER);

   // position and step arithmetic
   always_comb begin
      ang_diff = {angle_ff[31], angle_ff} - {cfg.zero_offset[31], cfg.zero_offset};
      pos_in   = sat33(ang_diff);
      d_in     = {pos_ff[31], pos_ff} - {prev_angle_ff[31], prev_angle_ff};
      // step = round(q2 / 2), half = round(q2 / 4), q2 = 2*pi*2^(F+1)/N truncated
      r2_inc   = {1'b0, div_quo} + 1'b1;
      r1_inc   = {2'b00, div_quo[DIV_W-1:1]} + 1'b1;
      step_in  = {{(33 - DIV_W){1'b0}}, r2_inc[DIV_W:1]};
      half_in  = {{(33 - DIV_W){1'b0}}, r1_inc[DIV_W:1]};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_POS;
         ST_POS:  state_in = div_start ? ST_DIV : ST_EXEC;
         ST_DIV:  if (div_done) state_in = ST_STEP;
         ST_STEP: state_in = ST_EXEC;
         ST_EXEC: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // mode behaviour, committed with the result
   always_comb begin
      knob_mode_in  = knob_mode_ff;
      prev_angle_in = prev_angle_ff;
      prev_speed_in = prev_speed_ff;
      target_in     = target_ff;
      drive_in      = drive_ff;
      detent_in     = detent_ff;

      spd_diff = {speed_ff[31], speed_ff} - {prev_speed_ff[31], prev_speed_ff};
      tgt_up   = {target_ff[31], target_ff} + step_ff;
      tgt_dn   = {target_ff[31], target_ff} - step_ff;

      if (kind_ff == KIND_MODE) begin
         knob_mode_in  = new_mode_ff;
         prev_angle_in = pos_ff;
         prev_speed_in = speed_ff;
         case (new_mode_ff)
            KNOB_INERTIA: begin
               drive_in  = DRV_VELOCITY;
               target_in = '0;
            end
            KNOB_ENCODER: begin
               drive_in      = DRV_ANGLE;
               target_in     = TGT_42;
               prev_angle_in = TGT_42;
            end
            KNOB_SPRING: begin
               drive_in  = DRV_ANGLE;
               target_in = TGT_42;
            end
            KNOB_DAMPED: begin
               drive_in  = DRV_VELOCITY;
               target_in = '0;
            end
            KNOB_SPIN: begin
               drive_in  = DRV_VELOCITY;
               target_in = TGT_SPIN;
            end
            default: ;
         endcase
      end else begin
         case (knob_mode_ff)
            KNOB_INERTIA: begin
               if (speed_ff > ONE_X || speed_ff < NONE_X) begin
                  if (spd_diff > TH_X || spd_diff < NTH_X) begin
                     target_in = speed_ff;
                  end
               end else begin
                  target_in = '0;
               end
               prev_speed_in = speed_ff;
            end
            KNOB_ENCODER: begin
               if (d_ff > half_ff) begin
                  target_in     = sat33(tgt_up);
                  prev_angle_in = target_in;
                  detent_in     = detent_ff + 32'd1;
               end else if (d_ff < -half_ff) begin
                  target_in     = sat33(tgt_dn);
                  prev_angle_in = target_in;
                  detent_in     = detent_ff - 32'd1;
               end
            end
            KNOB_DAMPED: begin
               if (cfg.limit_high != '0 && cfg.limit_low != '0) begin
                  if (pos_ff > cfg.limit_high) begin
                     drive_in  = DRV_ANGLE;
                     target_in = cfg.limit_high;
                  end else if (pos_ff < cfg.limit_low) begin
                     drive_in  = DRV_ANGLE;
                     target_in = cfg.limit_low;
                  end else begin
                     drive_in  = DRV_VELOCITY;
                     target_in = '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         knob_mode_ff  <= KNOB_DISABLE;
         prev_angle_ff <= '0;
         prev_speed_ff <= '0;
         target_ff     <= '0;
         drive_ff      <= DRV_TORQUE;
         detent_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            knob_mode_ff  <= knob_mode_in;
            prev_angle_ff <= prev_angle_in;
            prev_speed_ff <= prev_speed_in;
            target_ff     <= target_in;
            drive_ff      <= drive_in;
            detent_ff     <= detent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         new_mode_ff <= req_new_mode;
         angle_ff    <= req_shaft_angle;
         speed_ff    <= req_shaft_speed;
      end
      if (state_ff == ST_POS) begin
         pos_ff <= pos_in;
      end
      if (state_ff == ST_STEP) begin
         d_ff    <= d_in;
         half_ff <= half_in;
         step_ff <= step_in;
      end
      if (commit) begin
         rsp_drive_ff    <= drive_in;
         rsp_setpoint_ff <= target_in;
         rsp_detent_ff   <= detent_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_mode   = rsp_drive_ff;
   assign rsp_setpoint     = rsp_setpoint_ff;
   assign rsp_detent_index = rsp_detent_ff;

endmodule

// ===== sv/hkms_div.sv =====
// Bit-serial restoring divider: W-bit dividend by 8-bit divisor, one bit per cycle.
module hkms_div #(
   parameter int W = hkms_pkg::FRAC_BITS_DEF + 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [7:0]   divisor,
   input  logic [W-1:0] dividend,
   output logic         done,
   output logic [W-1:0] quotient
);
   import hkms_pkg::*;

   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    rem_ff, rem_in;
   logic [7:0]    div_ff, div_in;
   logic [W-1:0]  quo_ff, quo_in;

   logic [8:0] trial;
   logic [8:0] diff;
   logic       ge;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      diff  = trial - {1'b0, div_ff};
      ge    = (trial >= {1'b0, div_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[7:0] : trial[7:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/hkms_csr.sv =====
// Configuration register file for the knob block.
module hkms_csr #(
   parameter int FRAC_BITS = hkms_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data,
   output hkms_pkg::cfg_type cfg
);
   import hkms_pkg::*;

   localparam longint ONE_L      = longint'(1) << FRAC_BITS;
   localparam longint LIM_LOW_L  = (33 * ONE_L + 5) / 10;
   localparam longint LIM_HIGH_L = (51 * ONE_L + 5) / 10;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ZERO_OFFSET: cfg_in.zero_offset      = csr_data;
            CSR_LIMIT_LOW:   cfg_in.limit_low        = csr_data;
            CSR_LIMIT_HIGH:  cfg_in.limit_high       = csr_data;
            CSR_DETENTS:     cfg_in.detents_per_turn = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_offset      <= '0;
         cfg_ff.limit_low        <= 32'(LIM_LOW_L);
         cfg_ff.limit_high       <= 32'(LIM_HIGH_L);
         cfg_ff.detents_per_turn <= 8'd12;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ===== test/haptic_knob_mode_setpoint_top_test.sv =====
// Self-checking testbench for the haptic knob mode and setpoint block.
`timescale 1ns / 100ps

module haptic_knob_mode_setpoint_top_test;
   import hkms_pkg::*;

   localparam int     FRAC    = FRAC_BITS_DEF;
   localparam longint ONE_Q   = longint'(1) << FRAC;
   localparam longint S32_MAX = (longint'(1) << 31) - 1;
   localparam longint S32_MIN = -(longint'(1) << 31);

   typedef struct packed {
      logic               kind;
      logic [2:0]         new_mode;
      logic signed [31:0] angle;
      logic signed [31:0] speed;
   } knob_req_type;

   typedef struct packed {
      logic [1:0]         drive_mode;
      logic signed [31:0] setpoint;
      logic signed [31:0] detent_index;
   } knob_rsp_type;

   typedef struct packed {
      logic         known;
      knob_req_type req;
      knob_rsp_type rsp;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_kind;
   logic [2:0]         req_new_mode;
   logic signed [31:0] req_shaft_angle;
   logic signed [31:0] req_shaft_speed;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_drive_mode;
   logic signed [31:0] rsp_setpoint;
   logic signed [31:0] rsp_detent_index;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [31:0]        csr_data;

   // Predictor state and configuration copy
   cfg_type     cfg;
   logic [2:0]  knob_q;
   longint      last_angle, last_speed, target_q;
   logic [1:0]  drive_q;
   logic [31:0] detent_q;

   knob_rsp_type pending_setpoints[$];
   int           mismatches = 0;
   bit           quiet = 1'b0;

   // Directed rows; known rows carry a hand-written result
   dir_row_type dir_table [0:24] = '{
      '{1'b1, '{KIND_TICK, KNOB_DISABLE, 32'h0000_0000, 32'h0000_0000},
            '{DRV_TORQUE, 32'h0000_0000, 32'h0}},
      '{1'b1, '{KIND_MODE, KNOB_SPIN, 32'h7FFF_FFFF, 32'h8000_0000},
            '{DRV_VELOCITY, 32'h0014_0000, 32'h0}},
      '{1'b1, '{KIND_TICK, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF},
            '{DRV_VELOCITY, 32'h0014_0000, 32'h0}},
      '{1'b1, '{KIND_MODE, KNOB_SPRING, 32'h0000_0000, 32'h0000_0000},
            '{DRV_ANGLE, 32'h0004_3333, 32'h0}},
      '{1'b1, '{KIND_MODE, KNOB_DISABLE, 32'h1234_5678, 32'hFFFF_FFFF},
            '{DRV_ANGLE, 32'h0004_3333, 32'h0}},
      '{1'b1, '{KIND_MODE, KNOB_INERTIA, 32'h0000_0000, 32'h0000_0000},
            '{DRV_VELOCITY, 32'h0000_0000, 32'h0}},
      '{1'b1, '{KIND_TICK, 3'd0, 32'h0000_0000, 32'h7FFF_FFFF},
            '{DRV_VELOCITY, 32'h7FFF_FFFF, 32'h0}},
      '{1'b0, '{KIND_TICK, 3'd5, 32'h0000_0000, 32'h7FFF_B333}, '0},
      '{1'b0, '{KIND_TICK, 3'd0, 32'h0000_0000, 32'h7FFF_0000}, '0},
      '{1'b1, '{KIND_TICK, 3'd0, 32'h0000_0000, 32'h0001_0000},
            '{DRV_VELOCITY, 32'h0000_0000, 32'h0}},
      '{1'b0, '{KIND_TICK, 3'd0, 32'h0000_0000, 32'h0001_0001}, '0},
      '{1'b0, '{KIND_TICK, 3'd0, 32'h0000_0000, 32'hFFFE_FFFF}, '0},
      '{1'b1, '{KIND_TICK, 3'd0, 32'h0000_0000, 32'h8000_0000},
            '{DRV_VELOCITY, 32'h8000_0000, 32'h0}},
      '{1'b1, '{KIND_MODE, KNOB_DAMPED, 32'h0000_0000, 32'h0000_0000},
            '{DRV_VELOCITY, 32'h0000_0000, 32'h0}},
      '{1'b1, '{KIND_TICK, 3'd0, 32'h0005_199B, 32'h0000_0000},
            '{DRV_ANGLE, 32'h0005_199A, 32'h0}},
      '{1'b1, '{KIND_TICK, 3'd0, 32'h0005_199A, 32'h0000_0000},
            '{DRV_VELOCITY, 32'h0000_0000, 32'h0}},
      '{1'b1, '{KIND_TICK, 3'd0, 32'h0003_4CCC, 32'h0000_0000},
            '{DRV_ANGLE, 32'h0003_4CCD, 32'h0}},
      '{1'b1, '{KIND_TICK, 3'd0, 32'h8000_0000, 32'h0000_0000},
            '{DRV_ANGLE, 32'h0003_4CCD, 32'h0}},
      '{1'b1, '{KIND_MODE, KNOB_ENCODER, 32'h0000_0000, 32'h0000_0000},
            '{DRV_ANGLE, 32'h0004_3333, 32'h0}},
      '{1'b0, '{KIND_TICK, 3'd0, 32'h0004_7638, 32'h0000_0000}, '0},
      '{1'b0, '{KIND_TICK, 3'd0, 32'h0004_7639, 32'h0000_0000}, '0},
      '{1'b0, '{KIND_TICK, 3'd0, 32'h8000_0000, 32'h0000_0000}, '0},
      '{1'b0, '{KIND_TICK, 3'd0, 32'h7FFF_FFFF, 32'h0000_0000}, '0},
      '{1'b0, '{KIND_MODE, 3'd6, 32'h5A5A_A5A5, 32'hA5A5_5A5A}, '0},
      '{1'b0, '{KIND_TICK, 3'd7, 32'h0000_0000, 32'h7FFF_FFFF}, '0}
   };

   haptic_knob_mode_setpoint_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint sat_s32(longint x);
      if (x > S32_MAX) return S32_MAX;
      if (x < S32_MIN) return S32_MIN;
      return x;
   endfunction

   function automatic longint tenths_q(longint t);
      return (t * ONE_Q + 5) / 10;
   endfunction

   // round(mult * pi * 2^FRAC / n)
   function automatic longint pi_frac(logic [63:0] mult, logic [63:0] n);
      logic [63:0] q;
      q = (PI_Q48 * mult) / n;
      return longint'((q + (64'd1 << (47 - FRAC))) >> (48 - FRAC));
   endfunction

   function automatic logic [63:0] detent_count();
      return (cfg.detents_per_turn != 8'd0) ? 64'(cfg.detents_per_turn) : 64'd1;
   endfunction

   // Advance the knob state by one transfer and return the expected result
   function automatic knob_rsp_type knob_step(knob_req_type r);
      longint       pos, spd, d, half, stride;
      knob_rsp_type res;
      pos = sat_s32(longint'($signed(r.angle)) - longint'($signed(cfg.zero_offset)));
      spd = longint'($signed(r.speed));
      if (r.kind == KIND_MODE) begin
         knob_q     = r.new_mode;
         last_angle = pos;
         last_speed = spd;
         case (r.new_mode)
            KNOB_INERTIA, KNOB_DAMPED: begin
               drive_q  = DRV_VELOCITY;
               target_q = 0;
            end
            KNOB_ENCODER: begin
               drive_q    = DRV_ANGLE;
               target_q   = tenths_q(42);
               last_angle = target_q;
            end
            KNOB_SPRING: begin
               drive_q  = DRV_ANGLE;
               target_q = tenths_q(42);
            end
            KNOB_SPIN: begin
               drive_q  = DRV_VELOCITY;
               target_q = 20 * ONE_Q;
            end
            default: ;
         endcase
      end else begin
         case (knob_q)
            KNOB_INERTIA: begin
               if (spd > ONE_Q || spd < -ONE_Q) begin
                  d = spd - last_speed;
                  if (d < 0) d = -d;
                  if (d > tenths_q(3)) target_q = spd;
               end else begin
                  target_q = 0;
               end
               last_speed = spd;
            end
            KNOB_ENCODER: begin
               half   = pi_frac(64'd1, detent_count());
               stride = pi_frac(64'd2, detent_count());
               d      = pos - last_angle;
               if (d > half) begin
                  target_q   = sat_s32(target_q + stride);
                  last_angle = target_q;
                  detent_q   = detent_q + 32'd1;
               end else if (d < -half) begin
                  target_q   = sat_s32(target_q - stride);
                  last_angle = target_q;
                  detent_q   = detent_q - 32'd1;
               end
            end
            KNOB_DAMPED: begin
               if (cfg.limit_high != 0 && cfg.limit_low != 0) begin
                  if (pos > longint'($signed(cfg.limit_high))) begin
                     drive_q  = DRV_ANGLE;
                     target_q = longint'($signed(cfg.limit_high));
                  end else if (pos < longint'($signed(cfg.limit_low))) begin
                     drive_q  = DRV_ANGLE;
                     target_q = longint'($signed(cfg.limit_low));
                  end else begin
                     drive_q  = DRV_VELOCITY;
                     target_q = 0;
                  end
               end
            end
            default: ;
         endcase
      end
      res.drive_mode   = drive_q;
      res.setpoint     = target_q[31:0];
      res.detent_index = detent_q;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] around(longint base, int spread);
      return 32'(base + longint'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // Random transfer, mostly aimed at the thresholds of the current mode
   function automatic knob_req_type next_knob_req();
      knob_req_type r;
      int           pick;
      longint       half, offs;
      r.kind     = KIND_TICK;
      r.new_mode = 3'($urandom);
      r.angle    = $urandom;
      r.speed    = $urandom;
      offs       = longint'($signed(cfg.zero_offset));
      half       = pi_frac(64'd1, detent_count());
      pick       = $urandom_range(0, 99);
      if (pick < 12) begin
         r.kind = KIND_MODE;
         case ($urandom_range(0, 11))
            8, 9: r.new_mode = KNOB_ENCODER;
            10: r.new_mode = KNOB_INERTIA;
            11: r.new_mode = KNOB_DAMPED;
            default: ;
         endcase
      end else if (pick < 85) begin
         case (knob_q)
            KNOB_INERTIA: begin
               if ($urandom_range(0, 1) == 1)
                  r.speed = around(last_speed + ($urandom_range(0, 1) ? tenths_q(3)
                                                                      : -tenths_q(3)), 4);
               else
                  r.speed = around($urandom_range(0, 1) ? ONE_Q : -ONE_Q, 4);
            end
            KNOB_ENCODER: begin
               case ($urandom_range(0, 3))
                  0: r.angle = around(last_angle + offs + half, 1);
                  1: r.angle = around(last_angle + offs - half, 1);
                  default: r.angle = around(last_angle + offs, int'(3 * half));
               endcase
            end
            KNOB_DAMPED: begin
               if ($urandom_range(0, 1) == 1)
                  r.angle = around(longint'($signed(cfg.limit_high)) + offs, 3);
               else
                  r.angle = around(longint'($signed(cfg.limit_low)) + offs, 3);
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic send_req(knob_req_type r, logic known, knob_rsp_type typed);
      int           gap;
      knob_rsp_type predicted;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= r.kind;
      req_new_mode    <= r.new_mode;
      req_shaft_angle <= r.angle;
      req_shaft_speed <= r.speed;
      do @(posedge clock); while (req_stall);
      predicted = knob_step(r);
      pending_setpoints.push_back(known ? typed : predicted);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ZERO_OFFSET: cfg.zero_offset = data;
         CSR_LIMIT_LOW: cfg.limit_low = data;
         CSR_LIMIT_HIGH: cfg.limit_high = data;
         CSR_DETENTS: cfg.detents_per_turn = data[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [31:0] offs, logic [31:0] lo, logic [31:0] hi,
                             logic [31:0] n);
      write_csr(CSR_ZERO_OFFSET, offs);
      write_csr(CSR_LIMIT_LOW, lo);
      write_csr(CSR_LIMIT_HIGH, hi);
      write_csr(CSR_DETENTS, n);
   endtask

   initial begin : rsp_stall_gen
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = pick_gap();
         @(negedge clock);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      knob_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_setpoints.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: drive %0d setpoint %0d detent %0d",
                        rsp_drive_mode, rsp_setpoint, rsp_detent_index);
         end else begin
            want = pending_setpoints.pop_front();
            if (want.drive_mode !== rsp_drive_mode || want.setpoint !== rsp_setpoint ||
                want.detent_index !== rsp_detent_index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: drive %0d/%0d setpoint %0d/%0d detent %0d/%0d (exp/act)",
                           want.drive_mode, rsp_drive_mode, want.setpoint, rsp_setpoint,
                           want.detent_index, rsp_detent_index);
            end
         end
      end
   end

   initial begin : stimulus
      knob_req_type item;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_TICK;
      req_new_mode    = KNOB_DISABLE;
      req_shaft_angle = '0;
      req_shaft_speed = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_ZERO_OFFSET;
      csr_data        = '0;
      cfg        = '{32'sd0, 32'(tenths_q(33)), 32'(tenths_q(51)), 8'd12};
      knob_q     = KNOB_DISABLE;
      last_angle = 0;
      last_speed = 0;
      target_q   = 0;
      drive_q    = DRV_TORQUE;
      detent_q   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) send_req(dir_table[i].req, dir_table[i].known, dir_table[i].rsp);

      for (int ph = 0; ph < 5; ph++) begin
         settle();
         quiet = (ph == 1);
         case (ph)
            0: set_config(around(0, 1 << 20), around(-100000, 90000), around(200000, 90000),
                          $urandom_range(1, 255));
            1: set_config(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd255);
            2: set_config(32'h7FFF_FFFF, 32'd0, around(300000, 1000), 32'd1);
            3: set_config(32'd0, around(-300000, 1000), 32'd0, 32'd0);
            default: set_config($urandom, $urandom, $urandom, $urandom_range(0, 255));
         endcase
         repeat (90) begin
            item = next_knob_req();
            send_req(item, 1'b0, '0);
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/hkms_pkg.sv
sv/hkms_div.sv
sv/hkms_csr.sv
sv/haptic_knob_mode_setpoint_top.sv
test/haptic_knob_mode_setpoint_top_test.sv
